/* hw/rtl/hosp_pkg.sv */
// shared types, constants and arithmetic helpers for the hybrid orbital surface point core
`timescale 1ns / 1ps
package hosp_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = FRAC_BITS + 4;
    localparam int VAL_BITS   = FRAC_BITS + 8;
    localparam int Q_BITS     = 33;
    localparam int SINE_DEPTH = 10;
    localparam int PIPE_DEPTH = 17;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 8;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HYBRID_KIND = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KEEP_POS    = 2'd1;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_INVALID = 3'd7;

    typedef logic signed [VAL_BITS-1:0] val_t;
    typedef logic signed [OUT_BITS-1:0] out_t;
    typedef logic signed [Q_BITS-1:0]   q30_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] phi_angle;
        logic [ANGLE_BITS-1:0] theta_angle;
    } angle_beat_t;

    typedef struct packed {
        logic point_valid;
        out_t point_x;
        out_t point_y;
        out_t point_z;
        out_t dphi_x;
        out_t dphi_y;
        out_t dphi_z;
        out_t dtheta_x;
        out_t dtheta_y;
        out_t dtheta_z;
    } surf_beat_t;

    localparam val_t ONE = val_t'(1) <<< FRAC_BITS;

    localparam logic signed [31:0] WEIGHT_Q30 [8][6] = '{
        '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
        '{32'sd123657173, 32'sd370971518, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
        '{32'sd123657173, 32'sd428361012, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
        '{32'sd123657173, 32'sd262316476, 32'sd262316476, 32'sd262316476, 32'sd0, 32'sd0},
        '{32'sd151448488, 32'sd262316476, 32'sd0, 32'sd0, 32'sd0, 32'sd293278736},
        '{32'sd0, 32'sd0, 32'sd0, 32'sd370971518, 32'sd239461086, 32'sd0},
        '{32'sd123657173, 32'sd0, 32'sd0, 32'sd370971518, 32'sd239461086, 32'sd0},
        '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}
    };

    localparam q30_t SIN_Q30 [7] = '{
        33'sd1686629713, 33'sd693598668, 33'sd85569306, 33'sd5026995,
        33'sd172272, 33'sd3864, 33'sd61
    };

    function automatic val_t mulf(input val_t a, input val_t b);
        logic signed [2*VAL_BITS-1:0] prod;
        prod = a * b;
        prod = prod + ((2*VAL_BITS)'(1) << (FRAC_BITS-1));
        return prod[FRAC_BITS+VAL_BITS-1:FRAC_BITS];
    endfunction

    function automatic q30_t mulq30(input q30_t a, input q30_t b);
        logic signed [2*Q_BITS-1:0] prod;
        prod = a * b;
        prod = prod + ((2*Q_BITS)'(1) << 29);
        return prod[30+Q_BITS-1:30];
    endfunction

    function automatic val_t coef(input logic [2:0] kind, input int idx);
        logic signed [31:0] w;
        w = WEIGHT_Q30[kind][idx] + (32'sd1 <<< (29-FRAC_BITS));
        return val_t'(w >>> (30-FRAC_BITS));
    endfunction

    function automatic out_t sat(input val_t v);
        val_t hi;
        val_t lo;
        hi = val_t'((1 <<< (OUT_BITS-1)) - 1);
        lo = -val_t'(1 <<< (OUT_BITS-1));
        if (v > hi)
        begin
            return out_t'(hi);
        end
        if (v < lo)
        begin
            return out_t'(lo);
        end
        return v[OUT_BITS-1:0];
    endfunction

endpackage

/* hw/rtl/hosp_sine.sv */
// pipelined quarter-wave sine: polynomial in Q30 by Horner steps, one step per stage
`timescale 1ns / 1ps
module hosp_sine (
    input  logic                            clk,
    input  logic [hosp_pkg::SINE_DEPTH-1:0] en,
    input  logic [hosp_pkg::ANGLE_BITS-1:0] angle,
    output hosp_pkg::val_t                  sine
);

    localparam int AB = hosp_pkg::ANGLE_BITS;
    localparam int F  = hosp_pkg::FRAC_BITS;
    localparam int QB = hosp_pkg::Q_BITS;

    hosp_pkg::q30_t u_reg [0:7];
    logic           neg_reg [0:8];
    hosp_pkg::q30_t s_reg [1:6];
    hosp_pkg::q30_t p_reg [2:7];
    hosp_pkg::q30_t m_reg;
    hosp_pkg::val_t sine_reg;

    hosp_pkg::q30_t u_next;
    hosp_pkg::q30_t t_next;
    hosp_pkg::q30_t v_next;
    hosp_pkg::val_t sine_next;

    always_comb
    begin
        u_next = QB'(angle[AB-3:0]) <<< (30-(AB-2));
        if (angle[AB-2])
        begin
            u_next = (QB'(1) <<< 30) - u_next;
        end
        t_next = m_reg + (QB'(1) <<< (29-F));
        v_next = t_next >>> (30-F);
        if (v_next < 0)
        begin
            v_next = '0;
        end
        else if (v_next > (QB'(1) <<< F))
        begin
            v_next = QB'(1) <<< F;
        end
        sine_next = v_next[hosp_pkg::VAL_BITS-1:0];
        if (neg_reg[8])
        begin
            sine_next = -sine_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            u_reg[0]   <= u_next;
            neg_reg[0] <= angle[AB-1];
        end
        for (int k = 1; k <= 7; k++)
        begin
            if (en[k])
            begin
                u_reg[k] <= u_reg[k-1];
            end
        end
        for (int k = 1; k <= 8; k++)
        begin
            if (en[k])
            begin
                neg_reg[k] <= neg_reg[k-1];
            end
        end
        if (en[1])
        begin
            s_reg[1] <= hosp_pkg::mulq30(u_reg[0], u_reg[0]);
        end
        for (int k = 2; k <= 6; k++)
        begin
            if (en[k])
            begin
                s_reg[k] <= s_reg[k-1];
            end
        end
        if (en[2])
        begin
            p_reg[2] <= hosp_pkg::SIN_Q30[5]
                        - hosp_pkg::mulq30(hosp_pkg::SIN_Q30[6], s_reg[1]);
        end
        for (int k = 3; k <= 7; k++)
        begin
            if (en[k])
            begin
                p_reg[k] <= hosp_pkg::SIN_Q30[7-k] - hosp_pkg::mulq30(p_reg[k-1], s_reg[k-1]);
            end
        end
        if (en[8])
        begin
            m_reg <= hosp_pkg::mulq30(p_reg[7], u_reg[7]);
        end
        if (en[9])
        begin
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule

/* hw/rtl/hybrid_orbital_surface_point_core.sv */
// top level of the hybrid orbital surface point core
// One angle pair enters per clock unless the output stalls, and its point comes out
// through a fully pipelined datapath: 10 stages of sine evaluation (Horner steps of a Q30
// polynomial), 3 stages of basis products, 2 stages of weighted sums and 2 stages of
// output products, rounding and saturation. Each stage advances whenever the stage
// after it is empty or moving, so bubbles close up during a downstream stall.
// Configuration writes are always taken and must only arrive while the pipe is empty.
`timescale 1ns / 1ps
module hybrid_orbital_surface_point_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                angle_valid,
    output logic                                angle_ready,
    input  hosp_pkg::angle_beat_t               angle,
    output logic                                surf_valid,
    input  logic                                surf_ready,
    output hosp_pkg::surf_beat_t                surf,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hosp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [hosp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int N  = hosp_pkg::PIPE_DEPTH;
    localparam int AB = hosp_pkg::ANGLE_BITS;
    localparam logic [AB-1:0] QUARTER = AB'(1) << (AB-2);

    typedef hosp_pkg::val_t val_t;

    logic [2:0]   kind_reg;
    logic         keep_pos_reg;
    logic [N-1:0] v_reg;
    logic [N-1:0] en;

    val_t sp, cp, st, ct;

    val_t nx10_reg, ny10_reg, cc10_reg, ss10_reg, sc10_reg;
    val_t ctcp10_reg, ctsp10_reg, ctct10_reg, ctst10_reg, st10_reg, ct10_reg;
    val_t nx11_reg, ny11_reg, c2p11_reg, s2p11_reg, g4_11_reg, gt4_11_reg;
    val_t ctcp11_reg, ctsp11_reg, st11_reg, ct11_reg;
    val_t nx12_reg, ny12_reg, ct12_reg, st12_reg, ctcp12_reg, ctsp12_reg;
    val_t g4_12_reg, gt4_12_reg, g5_12_reg, gt5_12_reg, gp5_12_reg;
    val_t pr_reg [6];
    val_t pt_reg [1:5];
    val_t pp1_reg, pp2_reg, pp5_reg;
    val_t nx13_reg, ny13_reg, ct13_reg, st13_reg, gt1_13_reg, gt2_13_reg;
    val_t r14_reg, rt14_reg, rp14_reg;
    val_t nx14_reg, ny14_reg, ct14_reg, st14_reg, gt1_14_reg, gt2_14_reg;
    val_t arx_reg, ary_reg, arz_reg, rpnx_reg, rpny_reg, rpnz_reg, rnny_reg, rnx_reg;
    val_t rtnx_reg, rtny_reg, rtnz_reg, rgt1_reg, rgt2_reg, rnst_reg;
    logic keep15_reg;
    hosp_pkg::surf_beat_t surf_reg;

    val_t ar14;
    logic keep14;
    hosp_pkg::surf_beat_t surf_next;

    always_comb
    begin
        en[N-1] = !v_reg[N-1] || surf_ready;
        for (int k = N-2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign angle_ready = en[0];
    assign cfg_ready   = 1'b1;
    assign surf_valid  = v_reg[N-1];
    assign surf        = surf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= hosp_pkg::KIND_NONE;
            keep_pos_reg <= 1'b1;
            v_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_index == hosp_pkg::REG_HYBRID_KIND)
            begin
                kind_reg <= cfg_data[2:0];
            end
            if (cfg_valid && cfg_index == hosp_pkg::REG_KEEP_POS)
            begin
                keep_pos_reg <= cfg_data[0];
            end
            for (int k = 0; k < N; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= (k == 0) ? angle_valid : v_reg[k == 0 ? 0 : k-1];
                end
            end
        end
    end

    hosp_sine u_sin_phi (
        .clk   (clk),
        .en    (en[hosp_pkg::SINE_DEPTH-1:0]),
        .angle (angle.phi_angle),
        .sine  (sp)
    );

    hosp_sine u_cos_phi (
        .clk   (clk),
        .en    (en[hosp_pkg::SINE_DEPTH-1:0]),
        .angle (angle.phi_angle + QUARTER),
        .sine  (cp)
    );

    hosp_sine u_sin_theta (
        .clk   (clk),
        .en    (en[hosp_pkg::SINE_DEPTH-1:0]),
        .angle (angle.theta_angle),
        .sine  (st)
    );

    hosp_sine u_cos_theta (
        .clk   (clk),
        .en    (en[hosp_pkg::SINE_DEPTH-1:0]),
        .angle (angle.theta_angle + QUARTER),
        .sine  (ct)
    );

    always_comb
    begin
        ar14 = (r14_reg < 0) ? -r14_reg : r14_reg;
        if (keep_pos_reg)
        begin
            keep14 = !(r14_reg < -val_t'(1));
        end
        else
        begin
            keep14 = !(r14_reg > val_t'(1));
        end
        surf_next = '0;
        if (keep15_reg && kind_reg != hosp_pkg::KIND_NONE && kind_reg != hosp_pkg::KIND_INVALID)
        begin
            surf_next.point_valid = 1'b1;
            surf_next.point_x     = hosp_pkg::sat(arx_reg);
            surf_next.point_y     = hosp_pkg::sat(ary_reg);
            surf_next.point_z     = hosp_pkg::sat(arz_reg);
            surf_next.dphi_x      = hosp_pkg::sat(rpnx_reg + rnny_reg);
            surf_next.dphi_y      = hosp_pkg::sat(rpny_reg + rnx_reg);
            surf_next.dphi_z      = hosp_pkg::sat(rpnz_reg);
            surf_next.dtheta_x    = hosp_pkg::sat(rtnx_reg + rgt1_reg);
            surf_next.dtheta_y    = hosp_pkg::sat(rtny_reg + rgt2_reg);
            surf_next.dtheta_z    = hosp_pkg::sat(rtnz_reg + rnst_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        // basis products
        if (en[10])
        begin
            nx10_reg   <= hosp_pkg::mulf(st, cp);
            ny10_reg   <= hosp_pkg::mulf(st, sp);
            cc10_reg   <= hosp_pkg::mulf(cp, cp);
            ss10_reg   <= hosp_pkg::mulf(sp, sp);
            sc10_reg   <= hosp_pkg::mulf(sp, cp);
            ctcp10_reg <= hosp_pkg::mulf(ct, cp);
            ctsp10_reg <= hosp_pkg::mulf(ct, sp);
            ctct10_reg <= hosp_pkg::mulf(ct, ct);
            ctst10_reg <= hosp_pkg::mulf(ct, st);
            st10_reg   <= st;
            ct10_reg   <= ct;
        end
        if (en[11])
        begin
            nx11_reg   <= nx10_reg;
            ny11_reg   <= ny10_reg;
            c2p11_reg  <= cc10_reg - ss10_reg;
            s2p11_reg  <= sc10_reg <<< 1;
            g4_11_reg  <= val_t'(3) * ctct10_reg - hosp_pkg::ONE;
            gt4_11_reg <= -(val_t'(6) * ctst10_reg);
            ctcp11_reg <= ctcp10_reg;
            ctsp11_reg <= ctsp10_reg;
            st11_reg   <= st10_reg;
            ct11_reg   <= ct10_reg;
        end
        if (en[12])
        begin
            nx12_reg   <= nx11_reg;
            ny12_reg   <= ny11_reg;
            ct12_reg   <= ct11_reg;
            st12_reg   <= st11_reg;
            ctcp12_reg <= ctcp11_reg;
            ctsp12_reg <= ctsp11_reg;
            g4_12_reg  <= g4_11_reg;
            gt4_12_reg <= gt4_11_reg;
            g5_12_reg  <= hosp_pkg::mulf(st11_reg, c2p11_reg);
            gt5_12_reg <= hosp_pkg::mulf(ct11_reg, c2p11_reg);
            gp5_12_reg <= -(hosp_pkg::mulf(st11_reg, s2p11_reg) <<< 1);
        end
        // weighted terms
        if (en[13])
        begin
            pr_reg[0]  <= hosp_pkg::mulf(hosp_pkg::coef(kind_reg, 0), hosp_pkg::ONE);
            pr_reg[1]  <= hosp_pkg::mulf(hosp_pkg::coef(kind_reg, 1), nx12_reg);
            pr_reg[2]  <= hosp_pkg::mulf(hosp_pkg::coef(kind_reg, 2), ny12_reg);
            pr_reg[3]  <= hosp_pkg::mulf(hosp_pkg::coef(kind_reg, 3), ct12_reg);
            pr_reg[4]  <= hosp_pkg::mulf(hosp_pkg::coef(kind_reg, 4), g4_12_reg);
            pr_reg[5]  <= hosp_pkg::mulf(hosp_pkg::coef(kind_reg, 5), g5_12_reg);
            pt_reg[1]  <= hosp_pkg::mulf(hosp_pkg::coef(kind_reg, 1), ctcp12_reg);
            pt_reg[2]  <= hosp_pkg::mulf(hosp_pkg::coef(kind_reg, 2), ctsp12_reg);
            pt_reg[3]  <= hosp_pkg::mulf(hosp_pkg::coef(kind_reg, 3), -st12_reg);
            pt_reg[4]  <= hosp_pkg::mulf(hosp_pkg::coef(kind_reg, 4), gt4_12_reg);
            pt_reg[5]  <= hosp_pkg::mulf(hosp_pkg::coef(kind_reg, 5), gt5_12_reg);
            pp1_reg    <= hosp_pkg::mulf(hosp_pkg::coef(kind_reg, 1), -ny12_reg);
            pp2_reg    <= hosp_pkg::mulf(hosp_pkg::coef(kind_reg, 2), nx12_reg);
            pp5_reg    <= hosp_pkg::mulf(hosp_pkg::coef(kind_reg, 5), gp5_12_reg);
            nx13_reg   <= nx12_reg;
            ny13_reg   <= ny12_reg;
            ct13_reg   <= ct12_reg;
            st13_reg   <= st12_reg;
            gt1_13_reg <= ctcp12_reg;
            gt2_13_reg <= ctsp12_reg;
        end
        if (en[14])
        begin
            r14_reg    <= pr_reg[0] + pr_reg[1] + pr_reg[2] + pr_reg[3] + pr_reg[4] + pr_reg[5];
            rt14_reg   <= pt_reg[1] + pt_reg[2] + pt_reg[3] + pt_reg[4] + pt_reg[5];
            rp14_reg   <= pp1_reg + pp2_reg + pp5_reg;
            nx14_reg   <= nx13_reg;
            ny14_reg   <= ny13_reg;
            ct14_reg   <= ct13_reg;
            st14_reg   <= st13_reg;
            gt1_14_reg <= gt1_13_reg;
            gt2_14_reg <= gt2_13_reg;
        end
        // output products and lobe filter
        if (en[15])
        begin
            arx_reg    <= hosp_pkg::mulf(ar14, nx14_reg);
            ary_reg    <= hosp_pkg::mulf(ar14, ny14_reg);
            arz_reg    <= hosp_pkg::mulf(ar14, ct14_reg);
            rpnx_reg   <= hosp_pkg::mulf(rp14_reg, nx14_reg);
            rpny_reg   <= hosp_pkg::mulf(rp14_reg, ny14_reg);
            rpnz_reg   <= hosp_pkg::mulf(rp14_reg, ct14_reg);
            rnny_reg   <= hosp_pkg::mulf(r14_reg, -ny14_reg);
            rnx_reg    <= hosp_pkg::mulf(r14_reg, nx14_reg);
            rtnx_reg   <= hosp_pkg::mulf(rt14_reg, nx14_reg);
            rtny_reg   <= hosp_pkg::mulf(rt14_reg, ny14_reg);
            rtnz_reg   <= hosp_pkg::mulf(rt14_reg, ct14_reg);
            rgt1_reg   <= hosp_pkg::mulf(r14_reg, gt1_14_reg);
            rgt2_reg   <= hosp_pkg::mulf(r14_reg, gt2_14_reg);
            rnst_reg   <= hosp_pkg::mulf(r14_reg, -st14_reg);
            keep15_reg <= keep14;
        end
        if (en[16])
        begin
            surf_reg <= surf_next;
        end
    end

endmodule

/* hw/rtl/hosp_checker.sv */
// port-level checks for the hybrid orbital surface point core, bound to the top level
`timescale 1ns / 1ps
module hosp_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 angle_ready,
    input logic                 surf_valid,
    input logic                 surf_ready,
    input hosp_pkg::surf_beat_t surf,
    input logic                 cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        surf_valid && !surf_ready |=> surf_valid)
        else $error("result beat dropped before accept");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        surf_valid && !surf_ready |=> $stable(surf))
        else $error("result beat changed while stalled");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !surf_valid |-> angle_ready)
        else $error("input stalled with empty output");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        surf_valid && !surf.point_valid |-> surf == '0)
        else $error("rejected point carries nonzero fields");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind hybrid_orbital_surface_point_core hosp_checker u_hosp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .angle_ready (angle_ready),
    .surf_valid  (surf_valid),
    .surf_ready  (surf_ready),
    .surf        (surf),
    .cfg_ready   (cfg_ready)
);

/* verif/tb_hybrid_orbital_surface_point_core.sv */
// testbench for the hybrid orbital surface point core: predictor, scoreboard and random traffic
`timescale 1ns / 1ps
module tb_hybrid_orbital_surface_point_core;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PIPE_SLACK  = 24;

    localparam longint LOBE_WEIGHT [8][6] = '{
        '{0, 0, 0, 0, 0, 0},
        '{123657173, 370971518, 0, 0, 0, 0},
        '{123657173, 428361012, 0, 0, 0, 0},
        '{123657173, 262316476, 262316476, 262316476, 0, 0},
        '{151448488, 262316476, 0, 0, 0, 293278736},
        '{0, 0, 0, 370971518, 239461086, 0},
        '{123657173, 0, 0, 370971518, 239461086, 0},
        '{0, 0, 0, 0, 0, 0}
    };
    localparam longint SINE_TAYLOR [7] = '{
        1686629713, 693598668, 85569306, 5026995, 172272, 3864, 61
    };

    class surf_scoreboard;
        logic [2:0]            kind;
        logic                  keep_pos;
        hosp_pkg::surf_beat_t  expected_q[$];
        int                    errors;

        function new();
            kind     = hosp_pkg::KIND_NONE;
            keep_pos = 1'b1;
            errors   = 0;
        endfunction

        function longint mul_round(longint a, longint b, int fb);
            return (a * b + (longint'(1) <<< (fb - 1))) >>> fb;
        endfunction

        function longint mf(longint a, longint b);
            return mul_round(a, b, hosp_pkg::FRAC_BITS);
        endfunction

        function longint q30_round(longint v);
            return (v + (longint'(1) <<< (29 - hosp_pkg::FRAC_BITS)))
                   >>> (30 - hosp_pkg::FRAC_BITS);
        endfunction

        function longint sine(longint ang);
            longint u;
            longint s2;
            longint p;
            longint v;
            logic [1:0] quad;
            ang  = ang & 64'hffff;
            quad = ang[15:14];
            u    = (ang & 64'h3fff) <<< 16;
            if (quad[0])
            begin
                u = (longint'(1) <<< 30) - u;
            end
            s2 = mul_round(u, u, 30);
            p  = SINE_TAYLOR[6];
            for (int k = 5; k >= 0; k--)
            begin
                p = SINE_TAYLOR[k] - mul_round(p, s2, 30);
            end
            v = q30_round(mul_round(p, u, 30));
            if (v < 0)
            begin
                v = 0;
            end
            if (v > (longint'(1) <<< hosp_pkg::FRAC_BITS))
            begin
                v = longint'(1) <<< hosp_pkg::FRAC_BITS;
            end
            return quad[1] ? -v : v;
        endfunction

        function hosp_pkg::out_t clamp(longint v);
            if (v > 524287)
            begin
                v = 524287;
            end
            if (v < -524288)
            begin
                v = -524288;
            end
            return hosp_pkg::out_t'(v);
        endfunction

        function hosp_pkg::surf_beat_t predict(hosp_pkg::angle_beat_t a);
            hosp_pkg::surf_beat_t e;
            longint sp, cp, st, ct, nx, ny, c2p, s2p, r, rt, rp, ar, c;
            longint g[6];
            longint gt[6];
            longint gp[6];
            e  = '0;
            sp = sine(a.phi_angle);
            cp = sine(longint'(a.phi_angle) + 16384);
            st = sine(a.theta_angle);
            ct = sine(longint'(a.theta_angle) + 16384);
            if (kind == hosp_pkg::KIND_NONE || kind == hosp_pkg::KIND_INVALID)
            begin
                return e;
            end
            nx  = mf(st, cp);
            ny  = mf(st, sp);
            c2p = mf(cp, cp) - mf(sp, sp);
            s2p = 2 * mf(sp, cp);
            g[0] = 65536;                 gt[0] = 0;             gp[0] = 0;
            g[1] = nx;                    gt[1] = mf(ct, cp);    gp[1] = -ny;
            g[2] = ny;                    gt[2] = mf(ct, sp);    gp[2] = nx;
            g[3] = ct;                    gt[3] = -st;           gp[3] = 0;
            g[4] = 3 * mf(ct, ct) - 65536; gt[4] = -6 * mf(ct, st); gp[4] = 0;
            g[5] = mf(st, c2p);           gt[5] = mf(ct, c2p);   gp[5] = -2 * mf(st, s2p);
            r  = 0;
            rt = 0;
            rp = 0;
            for (int i = 0; i < 6; i++)
            begin
                c  = q30_round(LOBE_WEIGHT[kind][i]);
                r  += mf(c, g[i]);
                rt += mf(c, gt[i]);
                rp += mf(c, gp[i]);
            end
            if (keep_pos ? (r < -1) : (r > 1))
            begin
                return e;
            end
            ar = (r < 0) ? -r : r;
            e.point_valid = 1'b1;
            e.point_x  = clamp(mf(ar, nx));
            e.point_y  = clamp(mf(ar, ny));
            e.point_z  = clamp(mf(ar, ct));
            e.dphi_x   = clamp(mf(rp, nx) + mf(r, -ny));
            e.dphi_y   = clamp(mf(rp, ny) + mf(r, nx));
            e.dphi_z   = clamp(mf(rp, ct));
            e.dtheta_x = clamp(mf(rt, nx) + mf(r, gt[1]));
            e.dtheta_y = clamp(mf(rt, ny) + mf(r, gt[2]));
            e.dtheta_z = clamp(mf(rt, ct) + mf(r, -st));
            return e;
        endfunction

        function void note(hosp_pkg::angle_beat_t a);
            expected_q.push_back(predict(a));
        endfunction

        task report_mismatch(string field, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", field, got, want);
            errors++;
        endtask

        task check(hosp_pkg::surf_beat_t got);
            hosp_pkg::surf_beat_t e;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected beat", 0, 0);
                return;
            end
            e = expected_q.pop_front();
            if (got.point_valid !== e.point_valid)
                report_mismatch("point_valid", got.point_valid, e.point_valid);
            if (got.point_x !== e.point_x)   report_mismatch("point_x", got.point_x, e.point_x);
            if (got.point_y !== e.point_y)   report_mismatch("point_y", got.point_y, e.point_y);
            if (got.point_z !== e.point_z)   report_mismatch("point_z", got.point_z, e.point_z);
            if (got.dphi_x !== e.dphi_x)     report_mismatch("dphi_x", got.dphi_x, e.dphi_x);
            if (got.dphi_y !== e.dphi_y)     report_mismatch("dphi_y", got.dphi_y, e.dphi_y);
            if (got.dphi_z !== e.dphi_z)     report_mismatch("dphi_z", got.dphi_z, e.dphi_z);
            if (got.dtheta_x !== e.dtheta_x)
                report_mismatch("dtheta_x", got.dtheta_x, e.dtheta_x);
            if (got.dtheta_y !== e.dtheta_y)
                report_mismatch("dtheta_y", got.dtheta_y, e.dtheta_y);
            if (got.dtheta_z !== e.dtheta_z)
                report_mismatch("dtheta_z", got.dtheta_z, e.dtheta_z);
        endtask
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                angle_valid;
    logic                                angle_ready;
    hosp_pkg::angle_beat_t               angle;
    logic                                surf_valid;
    logic                                surf_ready;
    hosp_pkg::surf_beat_t                surf;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [hosp_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [hosp_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    surf_scoreboard sb = new();
    int cycles;
    int ready_hold;
    bit no_idle;

    hybrid_orbital_surface_point_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .angle_valid (angle_valid),
        .angle_ready (angle_ready),
        .angle       (angle),
        .surf_valid  (surf_valid),
        .surf_ready  (surf_ready),
        .surf        (surf),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(99);
        if (no_idle || pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(3, 1);
        if (pick < 97)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [15:0] rand_phi();
        if ($urandom_range(3) == 0)
            return {2'($urandom), 14'($urandom_range(2) == 0 ? 0 : 16383 - $urandom_range(2))};
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_theta();
        int pick;
        pick = $urandom_range(9);
        if (pick < 2)
            return 16'($urandom);
        if (pick < 3)
            return 16'($urandom_range(2) == 0 ? 0 : 32768 - $urandom_range(2));
        return 16'($urandom_range(32768));
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: check accepted beats, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (surf_valid && surf_ready)
            begin
                sb.check(surf);
            end
            if (ready_hold > 0)
            begin
                ready_hold <= ready_hold - 1;
            end
            else
            begin
                surf_ready <= no_idle || ($urandom_range(2) != 0);
                ready_hold <= gap_len();
            end
        end
    end

    task automatic write_cfg(logic [hosp_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [hosp_pkg::CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (idx == hosp_pkg::REG_HYBRID_KIND)
            sb.kind = data[2:0];
        else if (idx == hosp_pkg::REG_KEEP_POS)
            sb.keep_pos = data[0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_angle(logic [15:0] phi, logic [15:0] theta);
        hosp_pkg::angle_beat_t a;
        int gap;
        a.phi_angle   = phi;
        a.theta_angle = theta;
        angle_valid <= 1'b1;
        angle       <= a;
        do
        begin
            @(posedge clk);
        end
        while (!angle_ready);
        sb.note(a);
        gap = gap_len();
        if (gap > 0)
        begin
            angle_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        angle_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    task automatic run_phase(int count);
        send_angle(16'h0000, 16'h0000);
        send_angle(16'hffff, 16'h8000);
        send_angle(16'h4000, 16'h4000);
        send_angle(16'h8000, 16'h2000);
        send_angle(16'hc000, 16'h6000);
        send_angle(16'h2000, 16'hc000);
        send_angle(16'h6000, 16'hffff);
        send_angle(16'h1555, 16'h3fff);
        for (int i = 0; i < count; i++)
        begin
            send_angle(rand_phi(), rand_theta());
        end
        drain();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        angle_valid = 1'b0;
        angle       = '0;
        surf_ready  = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cycles      = 0;
        ready_hold  = 0;
        no_idle     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings first
        run_phase(4);
        for (int k = 0; k < 8; k++)
        begin
            for (int lobe = 1; lobe >= 0; lobe--)
            begin
                no_idle = ((k * 2 + lobe) % 3 == 0);
                write_cfg(hosp_pkg::REG_HYBRID_KIND, {5'($urandom), 3'(k)});
                write_cfg(hosp_pkg::REG_KEEP_POS, {7'($urandom), 1'(lobe)});
                run_phase(16);
            end
        end
        no_idle = 1'b0;
        if (sb.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
